>>> hdl/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
`timescale 1ns / 1ps

package chd_pkg;

    // Default table depth
    localparam int MAX_CODES_DEF = 256;
    // Longest code that can ever match
    localparam int MAX_CODE_LEN  = 31;

    localparam int SYM_W  = 32;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 31;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BIT   = 2'd2;
    localparam logic [1:0] OP_ZERO  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DECODED  = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_UNSUITED = 2'd3;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    // One result item
    typedef struct packed {
        logic [1:0]       status;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] bits;
    } t_result;

endpackage

>>> hdl/chd_table_ram.sv
// Code table RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module chd_table_ram #(
    parameter int MAX_CODES = chd_pkg::MAX_CODES_DEF,
    localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  chd_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output chd_pkg::t_entry  o_rdata
);

    chd_pkg::t_entry r_mem [MAX_CODES];
    chd_pkg::t_entry r_rdata;

    // Read before write on the same entry, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/chd_ctrl.sv
// Sequencer: sorted insert, code assignment sweep and decode scan over the table RAM.
`timescale 1ns / 1ps

module chd_ctrl #(
    parameter int MAX_CODES = chd_pkg::MAX_CODES_DEF,
    localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1,
    localparam int CW = $clog2(MAX_CODES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command transaction
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    input  logic [chd_pkg::SYM_W-1:0]  i_symbol,
    input  logic [chd_pkg::LEN_W-1:0]  i_code_length,
    input  logic                       i_stream_bit,
    // result hand-off to the output stage
    output logic                       o_res_valid,
    input  logic                       i_out_free,
    output chd_pkg::t_result           o_res,
    // table RAM
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output chd_pkg::t_entry            o_wdata,
    output logic [AW-1:0]              o_raddr,
    input  chd_pkg::t_entry            i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_ASG,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic [chd_pkg::CODE_W-1:0]   r_val, n_val;
    logic [chd_pkg::LEN_W-1:0]    r_cur_len, n_cur_len;
    logic [chd_pkg::CODE_W-1:0]   r_pcode, n_pcode;
    logic [chd_pkg::LEN_W-1:0]    r_plen, n_plen;
    logic [chd_pkg::LEN_W-1:0]    r_first_len, n_first_len;
    logic [chd_pkg::SYM_W-1:0]    r_first_sym, n_first_sym;
    logic [chd_pkg::SYM_W-1:0]    r_new_sym, n_new_sym;
    logic [chd_pkg::LEN_W-1:0]    r_new_len, n_new_len;
    chd_pkg::t_result             r_res, n_res;

    logic                         accept;
    logic                         rd_issue;
    logic                         rd_after;
    logic                         more;
    logic [chd_pkg::CODE_W-1:0]   step_val;
    logic [chd_pkg::CODE_W-1:0]   asg_val;
    logic                         table_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    // Stored entry sorts strictly after the one being inserted
    assign rd_after = (i_rdata.len != r_new_len) ? (i_rdata.len > r_new_len)
                    : ($signed(i_rdata.sym) > $signed(r_new_sym));

    // Another entry follows the one at r_ptr
    assign more = ((CW'(r_ptr) + CW'(1)) < r_count);

    // Canonical code of the entry being swept
    assign step_val = (r_ptr == '0) ? '0 : (r_val + chd_pkg::CODE_W'(1));
    assign asg_val  = (i_rdata.len > r_cur_len) ? (step_val << (i_rdata.len - r_cur_len))
                                                : step_val;

    assign table_ok = (r_count != '0) && (r_first_len != '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_val       = r_val;
        n_cur_len   = r_cur_len;
        n_pcode     = r_pcode;
        n_plen      = r_plen;
        n_first_len = r_first_len;
        n_first_sym = r_first_sym;
        n_new_sym   = r_new_sym;
        n_new_len   = r_new_len;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_ptr;
        o_wdata     = i_rdata;
        o_raddr     = '0;
        rd_issue    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '{status: chd_pkg::ST_DECODED, sym: '0, bits: '0};
                    case (i_op)
                        chd_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_pcode = '0;
                            n_plen  = '0;
                        end
                        chd_pkg::OP_LOAD: begin
                            if (r_count == CW'(MAX_CODES)) begin
                                n_res.status = chd_pkg::ST_FULL;
                                n_state      = S_EMIT;
                            end else begin
                                n_new_sym = i_symbol;
                                n_new_len = i_code_length;
                                n_pcode   = '0;
                                n_plen    = '0;
                                n_ptr     = AW'(r_count);
                                if (r_count == '0) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    o_raddr  = AW'(r_count - CW'(1));
                                    rd_issue = 1'b1;
                                    n_state  = S_INS_CMP;
                                end
                            end
                        end
                        chd_pkg::OP_BIT: begin
                            if (!table_ok) begin
                                n_res.status = chd_pkg::ST_UNSUITED;
                                n_state      = S_EMIT;
                            end else begin
                                n_pcode  = {r_pcode[chd_pkg::CODE_W-2:0], i_stream_bit};
                                n_plen   = r_plen + chd_pkg::LEN_W'(1);
                                n_ptr    = '0;
                                rd_issue = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        chd_pkg::OP_ZERO: begin
                            if (r_count != '0 && r_first_len == '0) begin
                                n_res.sym = r_first_sym;
                            end else begin
                                n_res.status = chd_pkg::ST_UNSUITED;
                            end
                            n_state = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end

            // Walk down from the top, moving larger entries up one slot
            S_INS_CMP: begin
                if (rd_after) begin
                    o_we    = 1'b1;
                    o_waddr = r_ptr;
                    o_wdata = i_rdata;
                    n_ptr   = r_ptr - AW'(1);
                    if (r_ptr != AW'(1)) begin
                        o_raddr  = r_ptr - AW'(2);
                        rd_issue = 1'b1;
                    end else begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    n_state = S_INS_PUT;
                end
            end

            // Drop the new entry into the freed slot, then sweep codes if other entries exist
            S_INS_PUT: begin
                o_we      = 1'b1;
                o_waddr   = r_ptr;
                o_wdata   = '{sym: r_new_sym, len: r_new_len, code: '0};
                n_count   = r_count + CW'(1);
                n_val     = '0;
                if (r_ptr == '0) begin
                    // New first entry already carries code zero; sweep resumes at entry one
                    n_first_len = r_new_len;
                    n_first_sym = r_new_sym;
                    n_cur_len   = r_new_len;
                    if (r_count != '0) begin
                        o_raddr  = AW'(1);
                        rd_issue = 1'b1;
                        n_ptr    = AW'(1);
                        n_state  = S_ASG;
                    end else begin
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_ptr     = '0;
                    n_cur_len = '0;
                    rd_issue  = 1'b1;
                    n_state   = S_ASG;
                end
            end

            // Read-modify-write of each entry's canonical code
            S_ASG: begin
                o_we      = 1'b1;
                o_waddr   = r_ptr;
                o_wdata   = '{sym: i_rdata.sym, len: i_rdata.len, code: asg_val};
                n_val     = asg_val;
                if (i_rdata.len > r_cur_len) begin
                    n_cur_len = i_rdata.len;
                end
                if (r_ptr == '0) begin
                    n_first_len = i_rdata.len;
                    n_first_sym = i_rdata.sym;
                end
                if (more) begin
                    o_raddr  = r_ptr + AW'(1);
                    rd_issue = 1'b1;
                    n_ptr    = r_ptr + AW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end

            // Look for an entry whose length and code equal the partial code
            S_SCAN: begin
                if (i_rdata.len == r_plen && i_rdata.code == r_pcode) begin
                    n_res.sym  = i_rdata.sym;
                    n_res.bits = r_plen;
                    n_pcode    = '0;
                    n_plen     = '0;
                    n_state    = S_EMIT;
                end else if (more) begin
                    o_raddr  = r_ptr + AW'(1);
                    rd_issue = 1'b1;
                    n_ptr    = r_ptr + AW'(1);
                end else if (r_plen >= chd_pkg::LEN_W'(chd_pkg::MAX_CODE_LEN)) begin
                    n_res.status = chd_pkg::ST_NO_MATCH;
                    n_pcode      = '0;
                    n_plen       = '0;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // Hold the result until the output stage takes it
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pcode     <= '0;
            r_plen      <= '0;
            r_first_len <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pcode     <= n_pcode;
            r_plen      <= n_plen;
            r_first_len <= n_first_len;
        end
        r_ptr       <= n_ptr;
        r_val       <= n_val;
        r_cur_len   <= n_cur_len;
        r_first_sym <= n_first_sym;
        r_new_sym   <= n_new_sym;
        r_new_len   <= n_new_len;
        r_res       <= n_res;
    end

    // A read issued together with a write never targets the written entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && rd_issue) |-> (o_waddr != o_raddr))
        else $error("table read and write hit the same entry");

    // Entry count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CODES))
        else $error("entry count beyond table depth");

    // Partial code never grows past the longest code
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= chd_pkg::LEN_W'(chd_pkg::MAX_CODE_LEN))
        else $error("partial length beyond maximum");

    // A pending result is held until the output stage has room
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_out_free) |=> (r_state == S_EMIT && $stable(r_res)))
        else $error("pending result lost");

    // The count only grows by the insert step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS_PUT && r_count != '0) |=> (r_count <= $past(r_count)))
        else $error("entry count grew outside insert");

endmodule

>>> hdl/canonical_huffman_decoder.sv
// Top level of the canonical Huffman decoder: sequencer, table RAM and output register.
//
//   channel  direction  handshake                    payload
//   input    in         i_in_valid / o_in_ready      i_op, i_symbol, i_code_length, i_stream_bit
//   output   out        o_out_valid / i_out_ready    o_status, o_decoded_symbol, o_code_bits
//
// One transaction at a time, all table work through the single-port-pair RAM.
// Load writes the entry directly into an empty table, else with N entries present
// runs an insert walk, then one read-modify-write per entry for code assignment.
// Stream bit: one entry compared per cycle.
// Reset (synchronous, active low) empties the table; no clearing pass is run.
// A result waits in the output register; a new transaction is taken meanwhile
// and stalls only when its own result finds that register still full.
`timescale 1ns / 1ps

module canonical_huffman_decoder #(
    parameter int MAX_CODES = chd_pkg::MAX_CODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    input  logic signed [31:0]         i_symbol,
    input  logic [4:0]                 i_code_length,
    input  logic                       i_stream_bit,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic signed [31:0]         o_decoded_symbol,
    output logic [4:0]                 o_code_bits
);

    localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    chd_pkg::t_entry      wdata;
    chd_pkg::t_entry      rdata;
    logic                 res_valid;
    logic                 out_free;
    chd_pkg::t_result     res;

    logic                 r_out_valid;
    chd_pkg::t_result     r_out;

    chd_ctrl #(
        .MAX_CODES (MAX_CODES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_stream_bit  (i_stream_bit),
        .o_res_valid   (res_valid),
        .i_out_free    (out_free),
        .o_res         (res),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata)
    );

    chd_table_ram #(
        .MAX_CODES (MAX_CODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_decoded_symbol = r_out.sym;
    assign o_code_bits      = r_out.bits;

endmodule

>>> sim/canonical_huffman_decoder_test.sv
// Self-checking testbench for the canonical Huffman decoder.
`timescale 1ns / 1ps

module canonical_huffman_decoder_test;

    localparam int TABLE_DEPTH  = chd_pkg::MAX_CODES_DEF;
    localparam int RESET_CYCLES = 12;
    localparam int STIM_ITEMS   = 1750;
    localparam int IDLE_OFF_AT  = 1500;
    localparam int FILL_AT      = 600;
    // a load into a nearly full table walks every entry twice
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 100;
    localparam int CYCLE_LIMIT  = 5_000_000;

    // one command as presented on the input channel
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] sym;
        logic [4:0]  len;
        logic        sbit;
    } t_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_op = chd_pkg::OP_CLEAR;
    logic signed [31:0] i_symbol = '0;
    logic [4:0]        i_code_length = '0;
    logic              i_stream_bit = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic signed [31:0] o_decoded_symbol;
    logic [4:0]        o_code_bits;

    canonical_huffman_decoder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_symbol         (i_symbol),
        .i_code_length    (i_code_length),
        .i_stream_bit     (i_stream_bit),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_decoded_symbol (o_decoded_symbol),
        .o_code_bits      (o_code_bits)
    );

    // Shadow copy of the code table and the bit accumulator
    logic signed [chd_pkg::SYM_W-1:0] tbl_sym  [TABLE_DEPTH];
    logic [chd_pkg::LEN_W-1:0]        tbl_len  [TABLE_DEPTH];
    logic [chd_pkg::CODE_W-1:0]       tbl_code [TABLE_DEPTH];
    int                               tbl_count = 0;
    logic [chd_pkg::CODE_W-1:0]       acc_code = '0;
    logic [chd_pkg::LEN_W-1:0]        acc_len = '0;

    t_cmd             cmd_queue[$];
    chd_pkg::t_result result_queue[$];
    t_cmd             cur_cmd;

    int n_pushed = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_by_status [4] = '{0, 0, 0, 0};
    int longest_match = 0;
    int n_cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit no_idle = 1'b0;
    bit calm_stretch = 1'b0;
    bit table_filled = 1'b0;

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     n_cycles, result_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR: %s", msg);
    endtask

    function automatic chd_pkg::t_result make_result(logic [1:0] st, logic [31:0] sym,
                                                     logic [4:0] nbits);
        chd_pkg::t_result r;
        r.status = st;
        r.sym    = sym;
        r.bits   = nbits;
        return r;
    endfunction

    // Canonical code assignment over the sorted table
    function automatic void renumber_codes();
        logic [chd_pkg::CODE_W-1:0] val;
        int                         cur_len;
        int                         i;
        val = '0;
        cur_len = 0;
        for (i = 0; i < tbl_count; i++) begin
            if (i != 0)
                val = val + 1'b1;
            while (int'(tbl_len[i]) > cur_len) begin
                val = val << 1;
                cur_len++;
            end
            tbl_code[i] = val;
        end
    endfunction

    // Advance the shadow decoder by one command, queue its result if any
    task automatic predict_decode(input t_cmd c);
        logic signed [31:0] key_sym;
        int                 pos;
        int                 i;
        bit                 hit;
        key_sym = $signed(c.sym);
        hit = 1'b0;
        case (c.op)
            chd_pkg::OP_CLEAR: begin
                tbl_count = 0;
                acc_code = '0;
                acc_len = '0;
            end
            chd_pkg::OP_LOAD: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    result_queue.push_back(make_result(chd_pkg::ST_FULL, '0, '0));
                end else begin
                    // insert after every entry that sorts equal or lower
                    pos = tbl_count;
                    while (pos > 0 && (tbl_len[pos-1] > c.len ||
                           (tbl_len[pos-1] == c.len && tbl_sym[pos-1] > key_sym))) begin
                        tbl_len[pos] = tbl_len[pos-1];
                        tbl_sym[pos] = tbl_sym[pos-1];
                        pos--;
                    end
                    tbl_len[pos] = c.len;
                    tbl_sym[pos] = key_sym;
                    tbl_count++;
                    renumber_codes();
                    acc_code = '0;
                    acc_len = '0;
                end
            end
            chd_pkg::OP_ZERO: begin
                if (tbl_count > 0 && tbl_len[0] == 0)
                    result_queue.push_back(make_result(chd_pkg::ST_DECODED, tbl_sym[0], '0));
                else
                    result_queue.push_back(make_result(chd_pkg::ST_UNSUITED, '0, '0));
            end
            default: begin
                if (tbl_count == 0 || tbl_len[0] == 0) begin
                    result_queue.push_back(make_result(chd_pkg::ST_UNSUITED, '0, '0));
                end else begin
                    acc_code = {acc_code[chd_pkg::CODE_W-2:0], c.sbit};
                    acc_len = acc_len + 1'b1;
                    for (i = 0; i < tbl_count && !hit; i++) begin
                        if (tbl_len[i] == acc_len && tbl_code[i] == acc_code) begin
                            hit = 1'b1;
                            result_queue.push_back(make_result(chd_pkg::ST_DECODED,
                                                               tbl_sym[i], acc_len));
                        end
                    end
                    if (hit || acc_len >= chd_pkg::MAX_CODE_LEN) begin
                        if (!hit)
                            result_queue.push_back(make_result(chd_pkg::ST_NO_MATCH,
                                                               '0, '0));
                        acc_code = '0;
                        acc_len = '0;
                    end
                end
            end
        endcase
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_decode(cur_cmd);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    cur_cmd = cmd_queue.pop_front();
                    i_op          <= cur_cmd.op;
                    i_symbol      <= cur_cmd.sym;
                    i_code_length <= cur_cmd.len;
                    i_stream_bit  <= cur_cmd.sbit;
                    i_in_valid    <= 1'b1;
                    if (!no_idle && !calm_stretch && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 8);
                    if ($urandom_range(0, 99) == 0)
                        calm_stretch = !calm_stretch;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and checker
    always @(posedge i_clk) begin
        chd_pkg::t_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (result_queue.size() == 0) begin
                    note_error($sformatf("unexpected result status %0d sym %0d bits %0d",
                                         o_status, o_decoded_symbol, o_code_bits));
                end else begin
                    exp_res = result_queue.pop_front();
                    if (o_status !== exp_res.status || o_decoded_symbol !== exp_res.sym ||
                        o_code_bits !== exp_res.bits) begin
                        note_error($sformatf(
                            "result %0d: expected status %0d sym %0d bits %0d, got %0d %0d %0d",
                            n_checked, exp_res.status, $signed(exp_res.sym), exp_res.bits,
                            o_status, o_decoded_symbol, o_code_bits));
                    end
                end
                n_by_status[o_status]++;
                if (o_status == chd_pkg::ST_DECODED && int'(o_code_bits) > longest_match)
                    longest_match = int'(o_code_bits);
            end
            // receiver drops ready in bursts of random length, except when no_idle or calm_stretch is set
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (!no_idle && !calm_stretch && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 7);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus helpers
    task automatic push_cmd(input logic [1:0] op, input logic [31:0] sym,
                            input logic [4:0] len, input logic sbit);
        t_cmd c;
        c.op   = op;
        c.sym  = sym;
        c.len  = len;
        c.sbit = sbit;
        cmd_queue.push_back(c);
        n_pushed++;
    endtask

    function automatic logic [31:0] rand_symbol();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, 15);
        if (pick == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // op with random content in all its fields, used or ignored
    task automatic push_noise(input logic [1:0] op);
        push_cmd(op, rand_symbol(), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_codeword(input int idx);
        int b;
        for (b = int'(tbl_len[idx]) - 1; b >= 0; b--)
            push_cmd(chd_pkg::OP_BIT, rand_symbol(), 5'($urandom_range(0, 31)),
                     tbl_code[idx][b]);
    endtask

    // Mostly valid codewords from the current table, salted with stray ops
    task automatic stream_codewords(input int n);
        int w;
        int r;
        for (w = 0; w < n; w++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_noise(chd_pkg::OP_BIT);
            else if (r < 11)
                push_noise(chd_pkg::OP_ZERO);
            else if (r < 13)
                push_cmd(chd_pkg::OP_LOAD, rand_symbol(), 5'($urandom_range(1, 8)),
                         1'($urandom_range(0, 1)));
            else if (r < 14)
                push_noise(chd_pkg::OP_CLEAR);
            else if (tbl_count != 0)
                push_codeword($urandom_range(0, tbl_count - 1));
        end
    endtask

    task automatic await_accepted();
        while (n_accepted != n_pushed)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        int kind;
        int k;
        int j;
        int len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ops that do not suit an empty table
        push_cmd(chd_pkg::OP_ZERO, 32'h0, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        // lone zero-length code: request works, stream bits do not
        push_cmd(chd_pkg::OP_LOAD, 32'h8000_0000, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_ZERO, 32'hffff_ffff, 5'd31, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h7fff_ffff, 5'd31, 1'b0);
        push_cmd(chd_pkg::OP_LOAD, 32'h7fff_ffff, 5'd31, 1'b1);
        push_cmd(chd_pkg::OP_ZERO, 32'h0, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_CLEAR, 32'hffff_ffff, 5'd31, 1'b1);
        push_cmd(chd_pkg::OP_ZERO, 32'h0, 5'd0, 1'b0);
        // codes 0, 10, 110, 111 loaded out of order, symbols at the extremes
        push_cmd(chd_pkg::OP_LOAD, 32'h7fff_ffff, 5'd3, 1'b0);
        push_cmd(chd_pkg::OP_LOAD, -32'sd7, 5'd2, 1'b0);
        push_cmd(chd_pkg::OP_LOAD, 32'h8000_0000, 5'd3, 1'b0);
        push_cmd(chd_pkg::OP_LOAD, 32'd5, 5'd1, 1'b0);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);
        push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b0);
        // no match: only code is "0", stream of ones runs to the length limit
        push_cmd(chd_pkg::OP_CLEAR, 32'h0, 5'd0, 1'b0);
        push_cmd(chd_pkg::OP_LOAD, 32'd9, 5'd1, 1'b0);
        for (j = 0; j < chd_pkg::MAX_CODE_LEN; j++)
            push_cmd(chd_pkg::OP_BIT, 32'h0, 5'd0, 1'b1);

        // hold off until the decoder has drained completely
        await_accepted();
        while (result_queue.size() != 0)
            @(posedge i_clk);

        // Random phases
        while (n_pushed < STIM_ITEMS) begin
            if (n_pushed >= IDLE_OFF_AT)
                no_idle = 1'b1;
            await_accepted();
            kind = $urandom_range(0, 19);
            if (!table_filled && n_pushed >= FILL_AT) begin
                // fill the table, overflow it, then decode from the full table
                table_filled = 1'b1;
                push_noise(chd_pkg::OP_CLEAR);
                for (j = 0; j < TABLE_DEPTH + 2; j++)
                    push_cmd(chd_pkg::OP_LOAD, rand_symbol(), 5'($urandom_range(1, 10)),
                             1'($urandom_range(0, 1)));
                await_accepted();
                stream_codewords(20);
            end else if (kind == 0) begin
                // empty table
                push_noise(chd_pkg::OP_CLEAR);
                for (j = 0; j < 4; j++)
                    push_noise($urandom_range(0, 1) ? chd_pkg::OP_BIT : chd_pkg::OP_ZERO);
            end else if (kind == 1) begin
                // zero-length code sorted first
                push_noise(chd_pkg::OP_CLEAR);
                push_cmd(chd_pkg::OP_LOAD, rand_symbol(), 5'd0, 1'($urandom_range(0, 1)));
                k = $urandom_range(0, 3);
                for (j = 0; j < k; j++)
                    push_cmd(chd_pkg::OP_LOAD, rand_symbol(), 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
                for (j = 0; j < 6; j++)
                    push_noise($urandom_range(0, 1) ? chd_pkg::OP_BIT : chd_pkg::OP_ZERO);
            end else begin
                // kinds 2..4 use long codes, the rest mostly short ones
                if (kind <= 4 || tbl_count + 12 >= TABLE_DEPTH || $urandom_range(0, 4) != 0)
                    push_noise(chd_pkg::OP_CLEAR);
                k = $urandom_range(1, 12);
                for (j = 0; j < k; j++) begin
                    if (kind <= 4)
                        len = $urandom_range(24, 31);
                    else if ($urandom_range(0, 11) == 0)
                        len = $urandom_range(0, 31);
                    else
                        len = $urandom_range(2, 7);
                    push_cmd(chd_pkg::OP_LOAD, rand_symbol(), 5'(len),
                             1'($urandom_range(0, 1)));
                end
                await_accepted();
                stream_codewords(kind <= 4 ? $urandom_range(2, 4) : $urandom_range(10, 40));
            end
        end

        // drain, then give a slow trailing load time to misbehave
        await_accepted();
        while (result_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_queue.size() != 0)
            note_error($sformatf("%0d expected results never arrived", result_queue.size()));

        $display("Sent %0d transactions; checked %0d results:", n_accepted, n_checked);
        $display("  %0d decoded, %0d no-match, %0d full, %0d unsuited",
                 n_by_status[chd_pkg::ST_DECODED], n_by_status[chd_pkg::ST_NO_MATCH],
                 n_by_status[chd_pkg::ST_FULL], n_by_status[chd_pkg::ST_UNSUITED]);
        $display("Longest code decoded: %0d bits; mismatches: %0d", longest_match, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/chd_pkg.sv
hdl/chd_table_ram.sv
hdl/chd_ctrl.sv
hdl/canonical_huffman_decoder.sv
sim/canonical_huffman_decoder_test.sv
